// ===== rtl/core/idea_pkg.sv =====
package idea_pkg;

    localparam int ROUNDS_DEF = 8;
    localparam int WORD_W     = 16;
    localparam int BLOCK_W    = 64;
    localparam int KEY_W      = 128;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int STEP_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

    // multiply mod 2^16+1, word 0 stands for 2^16
    function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] xa;
        logic [16:0] xb;
        logic [33:0] prod;
        logic [15:0] lo;
        logic [16:0] hi;
        logic [17:0] diff;
        xa   = {(a == 16'd0), a};
        xb   = {(b == 16'd0), b};
        prod = {17'd0, xa} * {17'd0, xb};
        lo   = prod[15:0];
        hi   = prod[32:16];
        // 2^16 = -1 mod 2^16+1, so the value is lo - hi
        if ({1'b0, lo} >= hi)
        begin
            diff = {2'b00, lo} - {1'b0, hi};
        end
        else
        begin
            diff = {2'b00, lo} + 18'd65537 - {1'b0, hi};
        end
        return diff[15:0];
    endfunction

    function automatic logic [15:0] neg_word(input logic [15:0] a);
        return 16'd0 - a;
    endfunction

    // word k of the schedule: key rotated left by 25 per group of eight
    function automatic logic [15:0] enc_subkey(input logic [127:0] key, input int k);
        int           rot;
        logic [255:0] dbl;
        rot = (25 * (k >> 3) + 16 * (k & 7)) & 127;
        dbl = {key, key};
        return dbl[255 - rot -: 16];
    endfunction

endpackage

// ===== rtl/core/idea_block_cipher_core.sv =====
// 64-bit block cipher core with a 128-bit key (ECB primitive). Write key_high
// (index 0) and key_low (index 1) through the cfg port; each write starts a
// rebuild of the decryption schedule, which computes 2*(ROUNDS+1) inverses mod
// 65537 by square-and-multiply on one shared modular multiplier. in_ready stays
// low during the rebuild. After that the cipher pipeline takes one block per
// cycle while the output is not stalled, with mode 0 = encrypt and mode 1 =
// decrypt, mixed freely. The pipeline has three stages per round, one per
// dependent modular multiply, plus one for the output transformation. Stalls
// hold items in place and bubbles close up behind a waiting result.
module idea_block_cipher_core
    import idea_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [BLOCK_W-1:0]    data_block,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BLOCK_W-1:0]    result_block
);

    localparam int SUBKEYS = 6 * ROUNDS + 4;
    localparam int NSTAGE  = 3 * ROUNDS + 1;
    localparam int INV_N   = 2 * (ROUNDS + 1);
    localparam int IDX_W   = $clog2(INV_N);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(INV_N - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = {STEP_W{1'b1}};

    // key registers and the encryption schedule (pure wiring)
    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [15:0] ek [SUBKEYS];

    for (genvar k = 0; k < SUBKEYS; k++)
    begin : g_ek
        assign ek[k] = enc_subkey({key_high_reg, key_low_reg}, k);
    end

    // inverse unit: acc = acc^2, acc = acc*v, sixteen times -> v^65535
    logic              busy_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [STEP_W-1:0] step_reg;
    logic [15:0]       acc_reg;
    logic [15:0]       inv_reg [INV_N];
    logic [15:0]       inv_src [INV_N];
    logic [15:0]       inv_op;
    logic [15:0]       mul_b;
    logic [15:0]       mul_out;
    logic              cfg_hit;

    for (genvar g = 0; g <= ROUNDS; g++)
    begin : g_src
        assign inv_src[2*g]     = ek[6*g];
        assign inv_src[2*g + 1] = ek[6*g + 3];
    end

    assign inv_op  = inv_src[idx_reg];
    assign mul_b   = step_reg[0] ? inv_op : acc_reg;
    assign mul_out = mul_mod(acc_reg, mul_b);
    assign cfg_hit = cfg_write_en && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            step_reg     <= '0;
            acc_reg      <= 16'd1;
            for (int i = 0; i < INV_N; i++)
            begin
                inv_reg[i] <= '0;
            end
        end
        else if (cfg_hit)
        begin
            if (cfg_index == REG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
            else
            begin
                key_low_reg <= cfg_data;
            end
            // any key write restarts the rebuild from the first inverse
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            step_reg <= '0;
            acc_reg  <= 16'd1;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                inv_reg[idx_reg] <= mul_out;
                acc_reg          <= 16'd1;
                if (idx_reg == IDX_LAST)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            else
            begin
                acc_reg <= mul_out;
            end
        end
    end

    // cipher pipeline
    logic [15:0]       x_reg [NSTAGE][4];
    logic [15:0]       t_reg [ROUNDS];
    logic [NSTAGE-1:0] mode_reg;
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    // a stage loads when it is empty or its content moves on
    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_en
        if (s == NSTAGE - 1)
        begin : g_last
            assign en[s] = !valid_reg[s] || out_ready;
        end
        else
        begin : g_mid
            assign en[s] = !valid_reg[s] || en[s + 1];
        end
    end

    assign in_ready = en[0] && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NSTAGE; s++)
            begin
                if (en[s])
                begin
                    if (s == 0)
                    begin
                        valid_reg[s] <= in_valid && !busy_reg;
                    end
                    else
                    begin
                        valid_reg[s] <= valid_reg[s - 1];
                    end
                end
            end
        end
    end

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        localparam int SA = 3 * r;
        localparam int SB = SA + 1;
        localparam int SC = SA + 2;
        localparam int J  = ROUNDS - r;

        logic [15:0] kd [6];
        logic [15:0] ka [4];
        logic [15:0] kb;
        logic [15:0] kc;
        logic [15:0] ax [4];
        logic        am;
        logic [15:0] u;
        logic [15:0] v;

        // decryption keys come from the encryption group J, reversed
        assign kd[0] = inv_reg[2*J];
        assign kd[3] = inv_reg[2*J + 1];
        assign kd[4] = ek[6*(J - 1) + 4];
        assign kd[5] = ek[6*(J - 1) + 5];
        if (J == ROUNDS)
        begin : g_noswap
            assign kd[1] = neg_word(ek[6*J + 1]);
            assign kd[2] = neg_word(ek[6*J + 2]);
        end
        else
        begin : g_swap
            assign kd[1] = neg_word(ek[6*J + 2]);
            assign kd[2] = neg_word(ek[6*J + 1]);
        end

        if (r == 0)
        begin : g_in
            assign ax[0] = data_block[63:48];
            assign ax[1] = data_block[47:32];
            assign ax[2] = data_block[31:16];
            assign ax[3] = data_block[15:0];
            assign am    = mode;
        end
        else
        begin : g_chain
            assign ax[0] = x_reg[SA - 1][0];
            assign ax[1] = x_reg[SA - 1][1];
            assign ax[2] = x_reg[SA - 1][2];
            assign ax[3] = x_reg[SA - 1][3];
            assign am    = mode_reg[SA - 1];
        end

        for (genvar t = 0; t < 4; t++)
        begin : g_ka
            assign ka[t] = am ? kd[t] : ek[6*r + t];
        end
        assign kb = mode_reg[SA] ? kd[4] : ek[6*r + 4];
        assign kc = mode_reg[SB] ? kd[5] : ek[6*r + 5];

        assign u = mul_mod((x_reg[SB][1] ^ x_reg[SB][3]) + t_reg[r], kc);
        assign v = t_reg[r] + u;

        always_ff @(posedge clk)
        begin
            if (en[SA])
            begin
                x_reg[SA][0] <= mul_mod(ax[0], ka[0]);
                x_reg[SA][1] <= ax[1] + ka[1];
                x_reg[SA][2] <= ax[2] + ka[2];
                x_reg[SA][3] <= mul_mod(ax[3], ka[3]);
                mode_reg[SA] <= am;
            end
            if (en[SB])
            begin
                x_reg[SB]    <= x_reg[SA];
                t_reg[r]     <= mul_mod(x_reg[SA][2] ^ x_reg[SA][0], kb);
                mode_reg[SB] <= mode_reg[SA];
            end
            if (en[SC])
            begin
                x_reg[SC][0] <= x_reg[SB][0] ^ u;
                x_reg[SC][1] <= x_reg[SB][2] ^ u;
                x_reg[SC][2] <= x_reg[SB][1] ^ v;
                x_reg[SC][3] <= x_reg[SB][3] ^ v;
                mode_reg[SC] <= mode_reg[SB];
            end
        end
    end

    // output transformation, words leave as x1,x3,x2,x4
    localparam int SF = NSTAGE - 1;

    logic [15:0] kf_enc [4];
    logic [15:0] kf_dec [4];
    logic [15:0] kf [4];

    assign kf_dec[0] = inv_reg[0];
    assign kf_dec[1] = neg_word(ek[1]);
    assign kf_dec[2] = neg_word(ek[2]);
    assign kf_dec[3] = inv_reg[1];

    for (genvar t = 0; t < 4; t++)
    begin : g_kf
        assign kf_enc[t] = ek[6*ROUNDS + t];
        assign kf[t]     = mode_reg[SF - 1] ? kf_dec[t] : kf_enc[t];
    end

    always_ff @(posedge clk)
    begin
        if (en[SF])
        begin
            x_reg[SF][0] <= mul_mod(x_reg[SF - 1][0], kf[0]);
            x_reg[SF][1] <= x_reg[SF - 1][2] + kf[1];
            x_reg[SF][2] <= x_reg[SF - 1][1] + kf[2];
            x_reg[SF][3] <= mul_mod(x_reg[SF - 1][3], kf[3]);
            mode_reg[SF] <= mode_reg[SF - 1];
        end
    end

    assign out_valid    = valid_reg[SF];
    assign result_block = {x_reg[SF][0], x_reg[SF][1], x_reg[SF][2], x_reg[SF][3]};

    // checks
    a_rebuild_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !in_ready)
        else $error("input open during key schedule rebuild");

    a_rebuild_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(idx_reg) == IDX_LAST && $past(step_reg) == STEP_LAST)
        else $error("key schedule rebuild ended early");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[SF] && !out_ready |=> valid_reg[SF] && $stable(result_block))
        else $error("waiting result dropped");

endmodule
